[rtl/core/decimal_keypad_calculator_unit_defines.svh]
// ----------------------------------------------------------------------------
// decimal keypad calculator assertion macros
// shared concurrent assertion forms for the calculator rtl
// ----------------------------------------------------------------------------
`ifndef DECIMAL_KEYPAD_CALCULATOR_UNIT_DEFINES_SVH
`define DECIMAL_KEYPAD_CALCULATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define DKC_ASSERT_HOLDS(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define DKC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dkc_pkg.sv]
// ----------------------------------------------------------------------------
// dkc_pkg
// key codes, operator and lamp codes, widths and controller/datapath links
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dkc_pkg;

  localparam int OPERAND_DIGITS_DEF = 4;

  // shown result: at most eight decimal digits
  localparam int MAX_SHOWN   = 8;
  localparam int DIG_IW      = 3;
  localparam int RES_W       = 27;
  localparam logic [RES_W-1:0] SHOWN_LIMIT = 27'd99999999;

  // iteration counter covers recalc, divider, conversion and digit steps
  localparam int CNT_W       = 5;

  localparam int IN_DATA_W   = 8;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 48;
  localparam int VAL_W       = 14;
  localparam int DIGCNT_W    = 3;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef enum logic [2:0] {
    OP_DIGIT     = 3'd0,
    OP_BACKSPACE = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_EQUALS    = 3'd3,
    OP_ADD       = 3'd4,
    OP_SUB       = 3'd5,
    OP_MUL       = 3'd6,
    OP_DIV       = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    OPER_NONE = 3'd0,
    OPER_ADD  = 3'd1,
    OPER_SUB  = 3'd2,
    OPER_MUL  = 3'd3,
    OPER_DIV  = 3'd4
  } oper_e;

  typedef enum logic [2:0] {
    LAMP_OFF    = 3'd0,
    LAMP_ADD    = 3'd1,
    LAMP_SUB    = 3'd2,
    LAMP_MUL    = 3'd3,
    LAMP_DIV    = 3'd4,
    LAMP_EQUALS = 3'd5
  } lamp_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECALC,
    ST_STATUS,
    ST_CALC,
    ST_DIVIDE,
    ST_CLAMP,
    ST_CONVERT,
    ST_DIGITS
  } ctrl_state_e;

  typedef struct packed {
    logic             apply;
    logic             recalc;
    logic             calc;
    logic             div_step;
    logic             clamp;
    logic             conv_step;
    logic             emit_status;
    logic             emit_digit;
    logic             last;
    logic [CNT_W-1:0] idx;
  } dkc_cmd_t;

  typedef struct packed {
    logic is_divide;
    logic out_free;
    logic digit_zero;
  } dkc_sts_t;

endpackage

[rtl/core/dkc_ctrl.sv]
// ----------------------------------------------------------------------------
// dkc_ctrl
// sequencer for key handling, arithmetic, conversion and digit output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dkc_ctrl #(
  parameter int OPERAND_DIGITS = dkc_pkg::OPERAND_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [2:0]         in_opcode_i,
  output logic               in_ready_o,
  input  dkc_pkg::dkc_sts_t  sts_i,
  output dkc_pkg::dkc_cmd_t  cmd_o
);

  localparam int VW = $clog2(10**OPERAND_DIGITS);
  localparam logic [dkc_pkg::CNT_W-1:0] RECALC_END = dkc_pkg::CNT_W'(OPERAND_DIGITS - 1);
  localparam logic [dkc_pkg::CNT_W-1:0] DIVIDE_END = dkc_pkg::CNT_W'(VW - 1);
  localparam logic [dkc_pkg::CNT_W-1:0] CONV_END   = dkc_pkg::CNT_W'(dkc_pkg::RES_W - 1);
  localparam logic [dkc_pkg::CNT_W-1:0] DIGIT_TOP  = dkc_pkg::CNT_W'(dkc_pkg::MAX_SHOWN - 1);

  dkc_pkg::ctrl_state_e        state_q, state_d;
  logic [dkc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                        started_q, started_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dkc_pkg::ST_IDLE;
      cnt_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    started_d  = started_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.idx  = cnt_q;
    unique case (state_q)
      dkc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (dkc_pkg::opcode_e'(in_opcode_i) == dkc_pkg::OP_EQUALS) begin
            state_d = dkc_pkg::ST_CALC;
          end else begin
            cmd_o.apply = 1'b1;
            cnt_d       = '0;
            state_d     = dkc_pkg::ST_RECALC;
          end
        end
      end
      dkc_pkg::ST_RECALC: begin
        cmd_o.recalc = 1'b1;
        if (cnt_q == RECALC_END) begin
          state_d = dkc_pkg::ST_STATUS;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      dkc_pkg::ST_STATUS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d           = dkc_pkg::ST_IDLE;
        end
      end
      dkc_pkg::ST_CALC: begin
        cmd_o.calc = 1'b1;
        cnt_d      = '0;
        if (sts_i.is_divide) begin
          state_d = dkc_pkg::ST_DIVIDE;
        end else begin
          state_d = dkc_pkg::ST_CLAMP;
        end
      end
      dkc_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIVIDE_END) begin
          state_d = dkc_pkg::ST_CLAMP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      dkc_pkg::ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        cnt_d       = '0;
        state_d     = dkc_pkg::ST_CONVERT;
      end
      dkc_pkg::ST_CONVERT: begin
        cmd_o.conv_step = 1'b1;
        if (cnt_q == CONV_END) begin
          cnt_d     = DIGIT_TOP;
          started_d = 1'b0;
          state_d   = dkc_pkg::ST_DIGITS;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      dkc_pkg::ST_DIGITS: begin
        // leading zeros are dropped, the units digit always goes out
        if (!started_q && sts_i.digit_zero && (cnt_q != '0)) begin
          cnt_d = cnt_q - 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          cmd_o.last       = (cnt_q == '0);
          started_d        = 1'b1;
          if (cnt_q == '0) begin
            state_d = dkc_pkg::ST_IDLE;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = dkc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/dkc_datapath.sv]
// ----------------------------------------------------------------------------
// dkc_datapath
// operand stores, arithmetic, divider, bcd conversion and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dkc_datapath #(
  parameter int OPERAND_DIGITS = dkc_pkg::OPERAND_DIGITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [2:0]                      in_opcode_i,
  input  logic [3:0]                      in_digit_i,
  input  dkc_pkg::dkc_cmd_t               cmd_i,
  output dkc_pkg::dkc_sts_t               sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [dkc_pkg::OUT_DATA_W-1:0]  out_data_o,
  output logic                            out_kind_o,
  output logic                            out_last_o
);

  localparam int VW = $clog2(10**OPERAND_DIGITS);
  localparam int CW = $clog2(OPERAND_DIGITS + 1);
  localparam int IW = (OPERAND_DIGITS > 1) ? $clog2(OPERAND_DIGITS) : 1;
  localparam int PW = (2 * VW > dkc_pkg::RES_W) ? 2 * VW : dkc_pkg::RES_W;
  localparam int MW = 2 * VW;
  localparam logic [CW-1:0] FULL = CW'(OPERAND_DIGITS);

  logic [3:0]              lstore_q [OPERAND_DIGITS];
  logic [3:0]              rstore_q [OPERAND_DIGITS];
  logic [CW-1:0]           lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  dkc_pkg::oper_e          oper_q, oper_d;
  dkc_pkg::lamp_e          lamp_q, lamp_d;
  logic                    show_q, show_d;
  logic [VW-1:0]           lval_q, lval_d, rval_q, rval_d;
  logic [VW-1:0]           quo_q, quo_d, dvs_q, dvs_d;
  logic [VW:0]             rem_q, rem_d;
  logic [PW-1:0]           raw_q, raw_d;
  logic [dkc_pkg::RES_W-1:0] res_q, res_d;
  logic [3:0]              bcd_q [dkc_pkg::MAX_SHOWN];
  logic [3:0]              bcd_d [dkc_pkg::MAX_SHOWN];
  logic [3:0]              bcd_adj [dkc_pkg::MAX_SHOWN];

  logic                    lwe, rwe;
  logic [IW-1:0]           lwa, rwa, ridx;
  logic [CW-1:0]           step;
  logic [VW-1:0]           lbase, rbase;
  logic [MW-1:0]           prod;
  logic [VW:0]             rem_sh;
  logic                    rem_ge;
  logic [2:0]              oper_sel;
  logic [3:0]              cur_digit;

  logic                    out_valid_q;
  logic [dkc_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                    out_kind_q, out_last_q;
  logic                    load;

  assign ridx      = cmd_i.idx[IW-1:0];
  assign step      = CW'(cmd_i.idx);
  assign lbase     = (cmd_i.idx == '0) ? '0 : lval_q;
  assign rbase     = (cmd_i.idx == '0) ? '0 : rval_q;
  assign prod      = MW'(lval_q) * MW'(rval_q);
  assign rem_sh    = {rem_q[VW-1:0], quo_q[VW-1]};
  assign rem_ge    = (rem_sh >= {1'b0, dvs_q});
  assign oper_sel  = in_opcode_i - 3'(dkc_pkg::OP_EQUALS);
  assign cur_digit = bcd_q[cmd_i.idx[dkc_pkg::DIG_IW-1:0]];

  always_comb begin
    for (int k = 0; k < dkc_pkg::MAX_SHOWN; k++) begin
      bcd_adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
    end
  end

  always_comb begin
    lcnt_d = lcnt_q;
    rcnt_d = rcnt_q;
    oper_d = oper_q;
    lamp_d = lamp_q;
    show_d = show_q;
    lval_d = lval_q;
    rval_d = rval_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    raw_d  = raw_q;
    res_d  = res_q;
    bcd_d  = bcd_q;
    lwe    = 1'b0;
    rwe    = 1'b0;
    lwa    = lcnt_q[IW-1:0];
    rwa    = rcnt_q[IW-1:0];

    if (cmd_i.apply) begin
      unique case (dkc_pkg::opcode_e'(in_opcode_i))
        dkc_pkg::OP_DIGIT: begin
          if (in_digit_i <= dkc_pkg::DIGIT_MAX) begin
            show_d = 1'b0;
            if (oper_q != dkc_pkg::OPER_NONE) begin
              if (rcnt_q < FULL) begin
                rwe    = 1'b1;
                rcnt_d = rcnt_q + 1'b1;
              end
            end else if (lcnt_q < FULL) begin
              lwe    = 1'b1;
              lcnt_d = lcnt_q + 1'b1;
            end
          end
        end
        dkc_pkg::OP_BACKSPACE: begin
          if (oper_q != dkc_pkg::OPER_NONE) begin
            if (rcnt_q != '0) begin
              rcnt_d = rcnt_q - 1'b1;
            end
          end else if (lcnt_q != '0) begin
            lcnt_d = lcnt_q - 1'b1;
          end
        end
        dkc_pkg::OP_CLEAR: begin
          lcnt_d = '0;
          rcnt_d = '0;
          show_d = 1'b0;
          oper_d = dkc_pkg::OPER_NONE;
          lamp_d = dkc_pkg::LAMP_OFF;
        end
        dkc_pkg::OP_EQUALS: begin
          // handled by the calc command
        end
        default: begin
          // operator keys: taken only while the right operand is empty
          if (rcnt_q == '0) begin
            oper_d = dkc_pkg::oper_e'(oper_sel);
            lamp_d = dkc_pkg::lamp_e'(oper_sel);
          end
        end
      endcase
    end

    if (cmd_i.recalc) begin
      lval_d = (step < lcnt_q) ? (lbase << 3) + (lbase << 1) + VW'(lstore_q[ridx]) : lbase;
      rval_d = (step < rcnt_q) ? (rbase << 3) + (rbase << 1) + VW'(rstore_q[ridx]) : rbase;
    end

    if (cmd_i.calc) begin
      quo_d = lval_q;
      rem_d = '0;
      dvs_d = rval_q;
      unique case (oper_q)
        dkc_pkg::OPER_ADD: raw_d = PW'(lval_q) + PW'(rval_q);
        dkc_pkg::OPER_SUB: raw_d = (lval_q > rval_q) ? PW'(lval_q - rval_q) : '0;
        dkc_pkg::OPER_MUL: raw_d = PW'(prod);
        dkc_pkg::OPER_DIV: raw_d = '0;
        default:           raw_d = PW'(lval_q);
      endcase
      lcnt_d = '0;
      rcnt_d = '0;
      lval_d = '0;
      rval_d = '0;
      oper_d = dkc_pkg::OPER_NONE;
      lamp_d = dkc_pkg::LAMP_EQUALS;
      show_d = 1'b1;
    end

    if (cmd_i.div_step) begin
      rem_d = rem_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_d = {quo_q[VW-2:0], rem_ge};
      raw_d = PW'(quo_d);
    end

    if (cmd_i.clamp) begin
      res_d = (raw_q > PW'(dkc_pkg::SHOWN_LIMIT)) ? dkc_pkg::SHOWN_LIMIT
                                                  : dkc_pkg::RES_W'(raw_q);
      for (int k = 0; k < dkc_pkg::MAX_SHOWN; k++) begin
        bcd_d[k] = '0;
      end
    end

    // double dabble: one binary bit per step
    if (cmd_i.conv_step) begin
      bcd_d[0] = {bcd_adj[0][2:0], res_q[dkc_pkg::RES_W-1]};
      for (int k = 1; k < dkc_pkg::MAX_SHOWN; k++) begin
        bcd_d[k] = {bcd_adj[k][2:0], bcd_adj[k-1][3]};
      end
      res_d = {res_q[dkc_pkg::RES_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (lwe) begin
      lstore_q[lwa] <= in_digit_i;
    end
    if (rwe) begin
      rstore_q[rwa] <= in_digit_i;
    end
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    raw_q <= raw_d;
    res_q <= res_d;
    bcd_q <= bcd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q <= '0;
      rcnt_q <= '0;
      oper_q <= dkc_pkg::OPER_NONE;
      lamp_q <= dkc_pkg::LAMP_OFF;
      show_q <= 1'b0;
      lval_q <= '0;
      rval_q <= '0;
    end else begin
      lcnt_q <= lcnt_d;
      rcnt_q <= rcnt_d;
      oper_q <= oper_d;
      lamp_q <= lamp_d;
      show_q <= show_d;
      lval_q <= lval_d;
      rval_q <= rval_d;
    end
  end

  // output register
  assign load = cmd_i.emit_status | cmd_i.emit_digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q <= cmd_i.emit_digit;
      out_last_q <= cmd_i.emit_status | cmd_i.last;
      out_data_q <= {3'b000,
                     cmd_i.emit_digit ? cur_digit : 4'd0,
                     show_q,
                     lamp_q,
                     oper_q,
                     dkc_pkg::DIGCNT_W'(rcnt_q),
                     dkc_pkg::VAL_W'(rval_q),
                     dkc_pkg::DIGCNT_W'(lcnt_q),
                     dkc_pkg::VAL_W'(lval_q)};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

  assign sts_o.is_divide  = (oper_q == dkc_pkg::OPER_DIV) && (rval_q != '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.digit_zero = (cur_digit == 4'd0);

endmodule

[rtl/core/decimal_keypad_calculator_unit.sv]
// ----------------------------------------------------------------------------
// decimal_keypad_calculator_unit
// four-function decimal keypad calculator, one decoded key per transaction
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                         | tuser  | tlast
//  s_axis   | key in    | digit[3:0], zero pad                       | opcode | -
//  m_axis   | item out  | left_value, left_digits, right_value,      | kind   | last
//           |           | right_digits, operator_code, indicator,    |        |
//           |           | result_showing, result_digit, zero pad     |        |
//
//  a non-equals key is accepted, then one recalc step per digit position
//  rebuilds both operand values, then the status transaction goes out;
//  equals runs a calc step, a restoring divider of one quotient bit per
//  cycle (nonzero divisor only, 14 quotient bits at four digits), a clamp
//  step, 27 steps of shift-add-3 conversion and up to 8 digit items out
//  reset clears counts, operator, lamp and the output valid; operand stores
//  hold whatever they had and are read only below their counts
//  a stalled m_axis holds the sequencer at its output step, keys wait in idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_keypad_calculator_unit_defines.svh"

module decimal_keypad_calculator_unit #(
  parameter int OPERAND_DIGITS = dkc_pkg::OPERAND_DIGITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // key in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dkc_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // digit[3:0], pad
  input  logic [dkc_pkg::IN_USER_W-1:0]   s_axis_tuser,  // opcode[2:0]
  // items out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // left_value[13:0], left_digits[16:14], right_value[30:17],
  // right_digits[33:31], operator_code[36:34], indicator[39:37],
  // result_showing[40], result_digit[44:41], pad[47:45]
  output logic [dkc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tuser,  // kind
  output logic                            m_axis_tlast
);

  dkc_pkg::dkc_cmd_t cmd;
  dkc_pkg::dkc_sts_t sts;

  // sequencer: owns the handshake on the key side and all step counting
  dkc_ctrl #(
    .OPERAND_DIGITS (OPERAND_DIGITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // operand state, arithmetic units and the output register
  dkc_datapath #(
    .OPERAND_DIGITS (OPERAND_DIGITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_opcode_i (s_axis_tuser),
    .in_digit_i  (s_axis_tdata[3:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // a status transaction is always the only one for its key and carries no digit
  `DKC_ASSERT_HOLDS(a_status_single, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser,
    m_axis_tlast && (m_axis_tdata[44:41] == 4'd0), "status item not last or digit set")

  // result digits show the cleared entry with the equals lamp lit
  `DKC_ASSERT_HOLDS(a_digit_state, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
    (m_axis_tdata[36:34] == 3'(dkc_pkg::OPER_NONE)) &&
    (m_axis_tdata[39:37] == 3'(dkc_pkg::LAMP_EQUALS)) && m_axis_tdata[40],
    "result digit with stale entry state")

  // one key at a time: the sequencer leaves idle after every accepted key
  `DKC_ASSERT_NEXT(a_busy_after_key, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "key side ready right after a key")

  // datapath gets at most one action per cycle
  `DKC_ASSERT_HOLDS(a_one_action, clk_i, rst_ni, 1'b1,
    $onehot0({cmd.apply, cmd.recalc, cmd.calc, cmd.div_step, cmd.clamp, cmd.conv_step,
              cmd.emit_status, cmd.emit_digit}), "overlapping datapath commands")

endmodule

[test/decimal_keypad_calculator_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal keypad calculator checker
// watches both stream channels, keeps its own copy of the calculator state,
// queues the items every accepted key should produce and compares each
// output transaction field by field against the oldest queued item
// ----------------------------------------------------------------------------

module decimal_keypad_calculator_unit_checker
  import dkc_pkg::*;
#(
  parameter int OPERAND_DIGITS = OPERAND_DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // digit[3:0], pad
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // opcode[2:0]
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // left_value, left_digits, right_value, right_digits, operator_code,
  // indicator, result_showing, result_digit, pad
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tuser,  // kind
  input  logic                  m_axis_tlast,
  output int                    errors_o,
  output int                    pending_o,
  output int                    checked_o
);

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic                kind;
    logic [VAL_W-1:0]    left_value;
    logic [DIGCNT_W-1:0] left_digits;
    logic [VAL_W-1:0]    right_value;
    logic [DIGCNT_W-1:0] right_digits;
    logic [2:0]          operator_code;
    logic [2:0]          indicator;
    logic                result_showing;
    logic [3:0]          result_digit;
    logic                last;
  } calc_item_t;

  // calculator state as the keys should leave it
  logic [3:0] left_digs  [OPERAND_DIGITS];
  logic [3:0] right_digs [OPERAND_DIGITS];
  int         left_cnt;
  int         right_cnt;
  oper_e      pend_oper;
  logic       showing;
  lamp_e      lamp;

  calc_item_t expected_items [$];
  calc_item_t got_item;
  calc_item_t want_item;

  function automatic int unsigned operand_value(logic right_side);
    int unsigned v;
    int          cnt;
    v   = 0;
    cnt = right_side ? right_cnt : left_cnt;
    for (int i = 0; i < cnt; i++) begin
      v = v * 10 + (right_side ? right_digs[i] : left_digs[i]);
    end
    return v;
  endfunction

  // output item carrying the current entry state
  function automatic calc_item_t snapshot(logic kind, logic [3:0] digit, logic last);
    calc_item_t item;
    item.kind           = kind;
    item.left_value     = VAL_W'(operand_value(1'b0));
    item.left_digits    = DIGCNT_W'(left_cnt);
    item.right_value    = VAL_W'(operand_value(1'b1));
    item.right_digits   = DIGCNT_W'(right_cnt);
    item.operator_code  = pend_oper;
    item.indicator      = lamp;
    item.result_showing = showing;
    item.result_digit   = digit;
    item.last           = last;
    return item;
  endfunction

  task automatic apply_key(opcode_e op, logic [3:0] dg);
    int unsigned a;
    int unsigned b;
    int unsigned r;
    int          n;
    logic [3:0]  digs [MAX_SHOWN];
    if (op == OP_EQUALS) begin
      a = operand_value(1'b0);
      b = operand_value(1'b1);
      case (pend_oper)
        OPER_ADD: r = a + b;
        OPER_SUB: r = (a > b) ? a - b : 0;
        OPER_MUL: r = a * b;
        OPER_DIV: r = (b != 0) ? a / b : 0;
        default:  r = a;
      endcase
      if (r > SHOWN_LIMIT) r = SHOWN_LIMIT;
      lamp      = LAMP_EQUALS;
      left_cnt  = 0;
      right_cnt = 0;
      pend_oper = OPER_NONE;
      showing   = 1'b1;
      // least significant first here, emitted most significant first
      n = 0;
      do begin
        digs[n] = 4'(r % 10);
        r       = r / 10;
        n++;
      end while (r != 0 && n < MAX_SHOWN);
      for (int k = 0; k < n; k++) begin
        expected_items.push_back(snapshot(1'b1, digs[n - 1 - k], k == n - 1));
      end
    end else begin
      case (op)
        OP_DIGIT: begin
          // digits above nine are ignored outright
          if (dg <= DIGIT_MAX) begin
            showing = 1'b0;
            if (pend_oper != OPER_NONE) begin
              if (right_cnt < OPERAND_DIGITS) begin
                right_digs[right_cnt] = dg;
                right_cnt++;
              end
            end else if (left_cnt < OPERAND_DIGITS) begin
              left_digs[left_cnt] = dg;
              left_cnt++;
            end
          end
        end
        OP_BACKSPACE: begin
          if (pend_oper != OPER_NONE) begin
            if (right_cnt > 0) right_cnt--;
          end else if (left_cnt > 0) begin
            left_cnt--;
          end
        end
        OP_CLEAR: begin
          left_cnt  = 0;
          right_cnt = 0;
          showing   = 1'b0;
          pend_oper = OPER_NONE;
          lamp      = LAMP_OFF;
        end
        // an operator only lands while the right operand is empty
        OP_ADD: if (right_cnt == 0) begin
          pend_oper = OPER_ADD;
          lamp      = LAMP_ADD;
        end
        OP_SUB: if (right_cnt == 0) begin
          pend_oper = OPER_SUB;
          lamp      = LAMP_SUB;
        end
        OP_MUL: if (right_cnt == 0) begin
          pend_oper = OPER_MUL;
          lamp      = LAMP_MUL;
        end
        OP_DIV: if (right_cnt == 0) begin
          pend_oper = OPER_DIV;
          lamp      = LAMP_DIV;
        end
        default: ;
      endcase
      expected_items.push_back(snapshot(1'b0, 4'd0, 1'b1));
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors_o++;
    if (errors_o <= MAX_PRINTED) begin
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cnt  = 0;
      right_cnt = 0;
      pend_oper = OPER_NONE;
      showing   = 1'b0;
      lamp      = LAMP_OFF;
      expected_items.delete();
      errors_o  = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_key(opcode_e'(s_axis_tuser), s_axis_tdata[3:0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_item.kind           = m_axis_tuser;
        got_item.left_value     = m_axis_tdata[13:0];
        got_item.left_digits    = m_axis_tdata[16:14];
        got_item.right_value    = m_axis_tdata[30:17];
        got_item.right_digits   = m_axis_tdata[33:31];
        got_item.operator_code  = m_axis_tdata[36:34];
        got_item.indicator      = m_axis_tdata[39:37];
        got_item.result_showing = m_axis_tdata[40];
        got_item.result_digit   = m_axis_tdata[44:41];
        got_item.last           = m_axis_tlast;
        if (expected_items.size() == 0) begin
          report_mismatch("transaction with nothing expected", got_item.kind, 0);
        end else begin
          want_item = expected_items.pop_front();
          compare_field("kind", got_item.kind, want_item.kind);
          compare_field("left_value", got_item.left_value, want_item.left_value);
          compare_field("left_digits", got_item.left_digits, want_item.left_digits);
          compare_field("right_value", got_item.right_value, want_item.right_value);
          compare_field("right_digits", got_item.right_digits, want_item.right_digits);
          compare_field("operator_code", got_item.operator_code, want_item.operator_code);
          compare_field("indicator", got_item.indicator, want_item.indicator);
          compare_field("result_showing", got_item.result_showing,
                        want_item.result_showing);
          compare_field("result_digit", got_item.result_digit, want_item.result_digit);
          compare_field("last", got_item.last, want_item.last);
          compare_field("pad", m_axis_tdata[47:45], 0);
        end
        checked_o++;
      end
      pending_o = expected_items.size();
    end
  end

endmodule

[test/decimal_keypad_calculator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal keypad calculator testbench
// feeds decoded keys to the calculator: a directed run over the corner keys,
// then random expressions and noise keys, with bursty key input, patterned
// output stalls, one long output hold-off and two full drains; a checker
// beside the block predicts every output transaction and counts mismatches
// ----------------------------------------------------------------------------

module decimal_keypad_calculator_unit_tb;
  import dkc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int TOTAL_KEYS   = 170;
  localparam int HOLD_AT_KEY  = 70;    // long output hold-off starts here
  localparam int DRAIN_AT_KEY = 120;   // key input pauses here until drained
  localparam int LONG_STALL   = 400;
  localparam int TAIL_CYCLES  = 100;
  localparam int IDLE_LIMIT   = 3000;

  typedef enum {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;        // digit[3:0], pad
  logic [IN_USER_W-1:0]  s_axis_tuser  = OP_DIGIT;  // opcode[2:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  int errors;
  int pending;
  int checked;
  int keys_sent   = 0;
  int equals_sent = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit hold_off_go = 1'b0;
  bit hold_done   = 1'b0;
  bit drain_done  = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  decimal_keypad_calculator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  decimal_keypad_calculator_unit_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .errors_o      (errors),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // watchdog: any stretch with no transaction on either side this long is a hang
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("decimal_keypad_calculator_unit verification failed");
      $finish;
    end
  end

  // output side: the stall pattern is redrawn whenever its random run ends,
  // plus one long hold-off on request from the key process
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       stall_left;
    int       phase;
    mode       = RX_STEADY;
    mode_left  = 0;
    stall_left = 0;
    phase      = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        stall_left  = LONG_STALL;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      phase++;
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY:   m_axis_tready <= 1'b1;
          RX_COIN:     m_axis_tready <= $urandom_range(0, 1);
          RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:     m_axis_tready <= ((phase % 5) < 3);
        endcase
      end
    end
  end

  // key side idle: valid held low for an idle gap of length n
  task automatic idle_keys(int n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // one key transaction; keys come in bursts with random gaps between them
  task automatic press(opcode_e op, logic [3:0] dg);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3, 4:    gap = $urandom_range(9, 70);
        default: gap = $urandom_range(1, 8);
      endcase
      idle_keys(gap);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, dg};
    do @(posedge clk_i); while (!s_axis_tready);
    keys_sent++;
    if (op == OP_EQUALS) equals_sent++;
  endtask

  // drop valid and wait until every predicted item has come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // digits with the odd backspace mixed in
  task automatic enter_digits(int n);
    for (int i = 0; i < n; i++) begin
      press(OP_DIGIT, 4'($urandom_range(0, 9)));
      if ($urandom_range(0, 5) == 0) press(OP_BACKSPACE, 4'($urandom));
    end
  endtask

  // well-formed expression with random content; left length 0 keeps the
  // left operand earlier keys left, lengths past four overflow the operand
  task automatic random_expression();
    int left_len;
    int right_len;
    left_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 4);
    right_len = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(0, 4);
    if ($urandom_range(0, 4) == 0) press(OP_CLEAR, 4'($urandom));
    enter_digits(left_len);
    press(opcode_e'($urandom_range(OP_ADD, OP_DIV)), 4'($urandom));
    // reselect while the right operand is still empty
    if ($urandom_range(0, 9) == 0) press(opcode_e'($urandom_range(OP_ADD, OP_DIV)), 4'($urandom));
    enter_digits(right_len);
    // operator once the right operand has digits: refused unless it is empty
    if ($urandom_range(0, 7) == 0) press(opcode_e'($urandom_range(OP_ADD, OP_DIV)), 4'($urandom));
    press(OP_EQUALS, 4'($urandom));
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    press(OP_BACKSPACE, 4'd0);                          // backspace with nothing entered
    press(OP_DIGIT, 4'd15);                             // digit above nine, ignored
    repeat (4) press(OP_DIGIT, 4'd9);
    press(OP_DIGIT, 4'd0);                              // left operand full, dropped
    press(OP_MUL, 4'd0);
    repeat (4) press(OP_DIGIT, 4'd9);
    press(OP_ADD, 4'd0);                                // right operand has digits, refused
    press(OP_EQUALS, 4'd0);                             // widest result, eight digits
    press(OP_SUB, 4'd0);                                // operator right after equals
    press(OP_DIGIT, 4'd1);
    press(OP_EQUALS, 4'd0);                             // below zero shows 0
    press(OP_DIV, 4'd0);
    press(OP_EQUALS, 4'd0);                             // divide by zero
    press(OP_DIGIT, 4'd7);
    press(OP_EQUALS, 4'd0);                             // no operator, shows left
    press(OP_DIGIT, 4'd7);
    press(OP_DIV, 4'd0);
    press(OP_DIGIT, 4'd2);
    press(OP_EQUALS, 4'd0);                             // truncating divide
    press(OP_CLEAR, 4'd0);

    // random part: mostly expressions, some noise keys
    while (keys_sent < TOTAL_KEYS) begin
      if (!hold_done && keys_sent >= HOLD_AT_KEY) begin
        hold_done   = 1'b1;
        hold_off_go = 1'b1;   // keys keep coming while output is held off
      end
      if (!drain_done && keys_sent >= DRAIN_AT_KEY) begin
        drain_done = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) press(opcode_e'($urandom_range(0, 7)), 4'($urandom));
      end else begin
        random_expression();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d keys (%0d equals) and %0d output transactions",
             keys_sent, equals_sent, checked);
    $display("corner keys, random expressions and noise under bursty input and output stalls");
    if (errors == 0) begin
      $display("decimal_keypad_calculator_unit verification clean");
    end else begin
      $display("decimal_keypad_calculator_unit verification failed");
    end
    $finish;
  end

endmodule
